@@ hdl/depth_minmax_normalize_assert.svh @@
// Assertion macros for the depth min/max normalizer checker.
`ifndef DEPTH_MINMAX_NORMALIZE_ASSERT_SVH
`define DEPTH_MINMAX_NORMALIZE_ASSERT_SVH

// Same-cycle implication on i_clk.
`define DMM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on i_clk.
`define DMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/dmm_pkg.sv @@
// Shared types and constants for the depth min/max normalizer.
package dmm_pkg;

    localparam int GRAY_BITS  = 8;
    localparam int QUOT_STEPS = GRAY_BITS;

    localparam logic [GRAY_BITS-1:0] GRAY_WHITE = 8'd255;
    localparam logic [GRAY_BITS-1:0] GRAY_BLACK = 8'd0;

    typedef struct packed {
        logic                 special;
        logic [GRAY_BITS-1:0] value;
    } t_cls;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_div_state;

endpackage

@@ hdl/depth_minmax_normalize.sv @@
// Top level of the depth min/max normalizer: front end, request queue, divider.
// Input channel: i_valid / o_stall with i_mode, i_frame_start, i_depth.
//   A scan pixel (i_mode 0) updates the running min/max depth in its accept
//   cycle and gives no result; i_frame_start restarts min at far, max at 0.
//   A convert pixel (i_mode 1) yields one o_gray on the output channel.
// Output channel: o_valid / i_stall with o_gray.
// Scan pixels are taken one per cycle while the two-entry queue has room.
// A convert pixel passes from the queue through the divider's idle, divide and
// done states into the o_valid register; the divider settles one quotient bit
// per cycle over 8 steps; far-plane, flat and clamped pixels skip the divide.
// The divider takes a new convert pixel only after the last has left S_DONE.
// Convert pixels see min/max as left by all earlier accepted scan pixels.
// Reset clears min to far, max to 0, empties the queue and drops o_valid.
// While i_stall is high the result holds; the queue fills and then o_stall
// rises, holding back further pixels until the receiver drains.
module depth_minmax_normalize
    import dmm_pkg::*;
#(
    parameter int DEPTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic                 i_frame_start,
    input  logic [DEPTH_BITS:0]  i_depth,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [GRAY_BITS-1:0] o_gray
);

    localparam int DW = DEPTH_BITS + 1;
    localparam int QW = $bits(t_cls) + 2 * DW;

    logic                push;
    t_cls                f_cls;
    logic [DEPTH_BITS:0] f_num;
    logic [DEPTH_BITS:0] f_den;
    logic                q_full;
    logic                q_empty;
    logic                pop;
    logic [QW-1:0]       q_data;
    t_cls                b_cls;
    logic [DEPTH_BITS:0] b_num;
    logic [DEPTH_BITS:0] b_den;

    dmm_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_frame_start (i_frame_start),
        .i_depth       (i_depth),
        .i_full        (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_cls         (f_cls),
        .o_num         (f_num),
        .o_den         (f_den)
    );

    dmm_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cls, f_num, f_den}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_cls, b_num, b_den} = q_data;

    dmm_div #(.DEPTH_BITS(DEPTH_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cls   (b_cls),
        .i_num   (b_num),
        .i_den   (b_den),
        .o_pop   (pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_gray  (o_gray)
    );

endmodule

@@ hdl/dmm_front.sv @@
// Front end: accepts pixels, tracks min/max depth and classifies convert pixels.
module dmm_front
    import dmm_pkg::*;
#(
    parameter int DEPTH_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_mode,
    input  logic                i_frame_start,
    input  logic [DEPTH_BITS:0] i_depth,
    input  logic                i_full,
    output logic                o_stall,
    output logic                o_push,
    output t_cls                o_cls,
    output logic [DEPTH_BITS:0] o_num,
    output logic [DEPTH_BITS:0] o_den
);

    localparam logic [DEPTH_BITS:0] FAR_DEPTH = {1'b1, {DEPTH_BITS{1'b0}}};

    logic [DEPTH_BITS:0] r_min, n_min;
    logic [DEPTH_BITS:0] r_max, n_max;
    logic [DEPTH_BITS:0] base_min, base_max;
    logic                accept;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && i_mode;

    always_comb begin
        base_min = i_frame_start ? FAR_DEPTH : r_min;
        base_max = i_frame_start ? '0 : r_max;
        n_min    = r_min;
        n_max    = r_max;
        if (accept && !i_mode) begin
            n_min = (i_depth < base_min) ? i_depth : base_min;
            n_max = (i_depth > base_max) ? i_depth : base_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= FAR_DEPTH;
            r_max <= '0;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    always_comb begin
        o_cls.special = 1'b1;
        o_cls.value   = GRAY_BLACK;
        if (i_depth == FAR_DEPTH) begin
            o_cls.value = GRAY_BLACK;
        end else if (r_max <= r_min) begin
            o_cls.value = GRAY_WHITE;
        end else if (i_depth >= r_max) begin
            o_cls.value = GRAY_BLACK;
        end else if (i_depth <= r_min) begin
            o_cls.value = GRAY_WHITE;
        end else begin
            o_cls.special = 1'b0;
        end
        o_num = r_max - i_depth;
        o_den = r_max - r_min;
    end

endmodule

@@ hdl/dmm_fifo.sv @@
// Two-entry request queue between the front end and the divider.
module dmm_fifo #(
    parameter int WIDTH = 59
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/dmm_div.sv @@
// Back end: iterative 8-bit quotient divider and output register.
module dmm_div
    import dmm_pkg::*;
#(
    parameter int DEPTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  t_cls                 i_cls,
    input  logic [DEPTH_BITS:0]  i_num,
    input  logic [DEPTH_BITS:0]  i_den,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [GRAY_BITS-1:0] o_gray
);

    localparam int DW = DEPTH_BITS + 1;
    localparam int RW = DW + GRAY_BITS;
    localparam int SW = DW + QUOT_STEPS - 1;
    localparam logic [2:0] CNT_LAST = 3'(QUOT_STEPS - 1);

    t_div_state           r_state;
    logic [RW-1:0]        r_rem;
    logic [SW-1:0]        r_dsh;
    logic [GRAY_BITS-1:0] r_q;
    logic [2:0]           r_cnt;
    logic                 r_out_valid;
    logic [GRAY_BITS-1:0] r_gray;
    logic                 out_free;
    logic                 fits;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign fits     = ({1'b0, r_dsh} <= r_rem);
    assign o_valid  = r_out_valid;
    assign o_gray   = r_gray;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_rem <= {i_num, {GRAY_BITS{1'b0}}} - RW'(i_num);
                r_dsh <= {i_den, {(QUOT_STEPS-1){1'b0}}};
                r_q   <= i_cls.value;
                r_cnt <= CNT_LAST;
            end
            S_DIV: begin
                if (fits) begin
                    r_rem <= r_rem - RW'(r_dsh);
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= {r_q[GRAY_BITS-2:0], fits};
                r_cnt <= r_cnt - 3'd1;
            end
            S_DONE: begin
                r_q <= r_q;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_cls.special ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && (r_state == S_DONE)) begin
            r_gray <= r_q;
        end
    end

endmodule

@@ hdl/dmm_checker.sv @@
// Port-level checker for the depth min/max normalizer, bound to the top level.
`include "depth_minmax_normalize_assert.svh"

module dmm_checker
    import dmm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [GRAY_BITS-1:0] o_gray
);

    `DMM_ASSERT_NEXT(a_out_hold, i_rst_n && o_valid && i_stall, o_valid && $stable(o_gray), "stalled result changed")
    `DMM_ASSERT_NEXT(a_rst_valid, !i_rst_n, !o_valid, "result valid right after reset")
    `DMM_ASSERT_NEXT(a_rst_stall, !i_rst_n, !o_stall, "input stalled right after reset")
    `DMM_ASSERT_NOW(a_stall_busy, i_rst_n && $rose(o_stall), $past(i_valid), "stall rose with no request")

endmodule

bind depth_minmax_normalize dmm_checker u_dmm_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for the depth min/max normalizer: range tracking and grey conversion.
module tb;
    import dmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_BITS   = 24;
    localparam int DW           = DEPTH_BITS + 1;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1540;

    localparam logic MODE_SCAN    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    localparam logic [DW-1:0] FAR_DEPTH = DW'(1) << DEPTH_BITS;
    localparam logic [DW-1:0] MAX_DEPTH = {DW{1'b1}};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic                 i_mode        = MODE_SCAN;
    logic                 i_frame_start = 1'b0;
    logic [DW-1:0]        i_depth       = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [GRAY_BITS-1:0] o_gray;

    logic [DW-1:0]        range_min = FAR_DEPTH;
    logic [DW-1:0]        range_max = '0;
    logic [GRAY_BITS-1:0] gray_q[$];

    int   err_cnt    = 0;
    int   sent_cnt   = 0;
    bit   tx_idle_on = 1'b1;
    bit   rx_idle_on = 1'b1;
    int   hold_req   = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   rx_wait    = 0;
    int   quiet_cnt  = 0;

    depth_minmax_normalize #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_frame_start(i_frame_start),
        .i_depth      (i_depth),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_gray       (o_gray)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [GRAY_BITS-1:0] predict_gray(input logic [DW-1:0] d);
        logic [DW+8:0] num;
        logic [DW+8:0] den;
        if (d == FAR_DEPTH) return GRAY_BLACK;
        if (range_max <= range_min) return GRAY_WHITE;
        if (d >= range_max) return GRAY_BLACK;
        if (d <= range_min) return GRAY_WHITE;
        num = (DW+9)'(range_max - d) * 255;
        den = (DW+9)'(range_max - range_min);
        return GRAY_BITS'(num / den);
    endfunction

    task automatic accept_pixel(input logic mode, input logic fs, input logic [DW-1:0] d);
        if (mode == MODE_SCAN) begin
            if (fs) begin
                range_min = FAR_DEPTH;
                range_max = '0;
            end
            if (d < range_min) range_min = d;
            if (d > range_max) range_max = d;
        end else begin
            gray_q.push_back(predict_gray(d));
        end
    endtask

    task automatic send_pixel(input logic mode, input logic fs, input logic [DW-1:0] d);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_frame_start <= fs;
        i_depth       <= d;
        do @(posedge i_clk); while (o_stall);
        accept_pixel(mode, fs, d);
        sent_cnt++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (gray_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_depth(input int unsigned lo, input int unsigned hi);
        return DW'($urandom_range(hi, lo));
    endfunction

    task automatic test_directed();
        send_pixel(MODE_CONVERT, 1'b0, '0);
        send_pixel(MODE_CONVERT, 1'b0, FAR_DEPTH);
        send_pixel(MODE_CONVERT, 1'b1, MAX_DEPTH);
        send_pixel(MODE_SCAN,    1'b1, DW'(1000));
        send_pixel(MODE_CONVERT, 1'b0, DW'(1000));
        send_pixel(MODE_CONVERT, 1'b0, FAR_DEPTH);
        send_pixel(MODE_CONVERT, 1'b0, '0);
        send_pixel(MODE_SCAN,    1'b0, DW'(5000));
        send_pixel(MODE_CONVERT, 1'b0, DW'(3000));
        send_pixel(MODE_CONVERT, 1'b0, DW'(5000));
        send_pixel(MODE_CONVERT, 1'b0, DW'(6000));
        send_pixel(MODE_CONVERT, 1'b0, DW'(500));
        send_pixel(MODE_CONVERT, 1'b1, DW'(4000));
        send_pixel(MODE_SCAN,    1'b0, '0);
        send_pixel(MODE_SCAN,    1'b0, MAX_DEPTH);
        send_pixel(MODE_CONVERT, 1'b0, FAR_DEPTH);
        send_pixel(MODE_CONVERT, 1'b0, FAR_DEPTH + DW'(5));
        send_pixel(MODE_CONVERT, 1'b0, DW'(1));
        send_pixel(MODE_SCAN,    1'b1, FAR_DEPTH);
        send_pixel(MODE_CONVERT, 1'b0, FAR_DEPTH);
        send_pixel(MODE_CONVERT, 1'b0, DW'(7));
        send_pixel(MODE_SCAN,    1'b1, '0);
        send_pixel(MODE_SCAN,    1'b0, FAR_DEPTH);
        send_pixel(MODE_CONVERT, 1'b0, DW'(1));
        send_pixel(MODE_CONVERT, 1'b0, FAR_DEPTH - DW'(1));
    endtask

    task automatic test_random_frames(input int n_items);
        int unsigned lo;
        int unsigned hi;
        int          n_scan;
        int          n_conv;
        int          stop_at;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at) begin
            tx_idle_on =  ($urandom_range(0, 3) != 0);
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: begin
                    lo = 0;
                    hi = MAX_DEPTH;
                end
                1: begin
                    lo = 0;
                    hi = FAR_DEPTH;
                end
                2: begin
                    lo = $urandom_range(FAR_DEPTH, 0);
                    hi = lo + $urandom_range(255, 0);
                end
                default: begin
                    lo = FAR_DEPTH - $urandom_range(1000, 0);
                    hi = FAR_DEPTH + $urandom_range(1000, 0);
                end
            endcase
            n_scan = $urandom_range(1, 12);
            n_conv = $urandom_range(1, 12);
            for (int k = 0; k < n_scan; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_pixel(1'($urandom), 1'($urandom), DW'($urandom));
                end else begin
                    send_pixel(MODE_SCAN, (k == 0) && ($urandom_range(0, 7) != 0),
                               pick_depth(lo, hi));
                end
            end
            for (int k = 0; k < n_conv; k++) begin
                case ($urandom_range(0, 7))
                    0:       send_pixel(MODE_CONVERT, 1'($urandom), FAR_DEPTH);
                    1:       send_pixel(MODE_CONVERT, 1'($urandom), DW'($urandom));
                    2:       send_pixel(1'($urandom), 1'($urandom), DW'($urandom));
                    default: send_pixel(MODE_CONVERT, 1'($urandom), pick_depth(lo, hi));
                endcase
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req <= hold_req + 1;
        send_pixel(MODE_SCAN, 1'b1, pick_depth(0, FAR_DEPTH));
        send_pixel(MODE_SCAN, 1'b0, pick_depth(0, FAR_DEPTH));
        for (int k = 0; k < 60; k++) begin
            send_pixel(($urandom_range(0, 4) == 0) ? MODE_SCAN : MODE_CONVERT, 1'b0,
                       pick_depth(0, FAR_DEPTH));
        end
        tx_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        tx_idle_on = 1'b0;
        send_pixel(MODE_SCAN, 1'b1, pick_depth(0, MAX_DEPTH));
        for (int k = 0; k < 20; k++) begin
            send_pixel(MODE_CONVERT, 1'b0, pick_depth(0, MAX_DEPTH));
        end
        wait_drained();
        for (int k = 0; k < 20; k++) begin
            send_pixel(MODE_CONVERT, 1'b0, pick_depth(0, MAX_DEPTH));
        end
        tx_idle_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (o_valid && !i_stall) rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        logic [GRAY_BITS-1:0] exp_gray;
        if (i_rst_n && o_valid && !i_stall) begin
            if (gray_q.size() == 0) begin
                $display("%0t: unexpected gray, expected none, actual %0d", $time, o_gray);
                err_cnt++;
            end else begin
                exp_gray = gray_q.pop_front();
                if (o_gray !== exp_gray) begin
                    $display("%0t: gray mismatch, expected %0d, actual %0d",
                             $time, exp_gray, o_gray);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cnt = 0;
        end else begin
            quiet_cnt++;
            if (quiet_cnt >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, gray_q.size());
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames(RANDOM_ITEMS / 2);
        test_backpressure();
        test_sender_pause();
        test_random_frames(RANDOM_ITEMS / 2);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
